### hw/rtl/assert_macros.svh
// Assertion macros shared by the speed controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, inactive while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dmpsc_pkg.sv
// Shared types and constants of the DC motor PWM speed controller.
package dmpsc_pkg;

   localparam int DutyBitsDefault  = 10;
   localparam int CountBitsDefault = 8;

   localparam int DutyCeil  = 999;
   localparam int DutyReset = 500;

   localparam int StepW     = 9;
   localparam int MaxW      = 10;
   localparam int BaseW     = 12;
   localparam int GateW     = 16;
   localparam int IntervalW = 4;
   localparam int PhaseW    = 12;

   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 16;
   localparam int ReqDataW = 8;

   localparam logic [StepW-1:0]     StepReset     = StepW'(100);
   localparam logic [MaxW-1:0]      MaxReset      = MaxW'(960);
   localparam logic [BaseW-1:0]     BaseReset     = BaseW'(1001);
   localparam logic [GateW-1:0]     GateReset     = GateW'(46080);
   localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(3);

   typedef enum logic [CsrAddrW-1:0] {
      CSR_DUTY_STEP,
      CSR_DUTY_MAX,
      CSR_PERIOD_BASE,
      CSR_GATE_TICKS,
      CSR_GATE_INTERVALS
   } csr_index_type;

   typedef struct packed {
      logic [StepW-1:0]     duty_step;
      logic [MaxW-1:0]      duty_max;
      logic [BaseW-1:0]     period_base;
      logic [GateW-1:0]     gate_ticks;
      logic [IntervalW-1:0] gate_intervals;
   } cfg_type;

   // Packed from the top bit down, so key_up lands in bit 0.
   typedef struct packed {
      logic enc_b_level;
      logic enc_edge;
      logic key_reverse;
      logic key_down;
      logic key_up;
   } req_type;

endpackage

### hw/rtl/dmpsc_drive.sv
// Duty setting, direction pair and PWM phase generator.
`include "assert_macros.svh"

module dmpsc_drive
   import dmpsc_pkg::*;
#(
   parameter int DUTY_BITS = DutyBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  cfg_type              cfg,
   input  req_type              req,
   output logic                 pwm_level,
   output logic                 drive_a,
   output logic [DUTY_BITS-1:0] duty_now
);

   localparam int SumW = ((DUTY_BITS > MaxW) ? DUTY_BITS : MaxW) + 1;
   localparam int LenW = ((DUTY_BITS + 1) > PhaseW) ? (DUTY_BITS + 1) : PhaseW;
   localparam logic [SumW-1:0] DutyMaskW = SumW'((64'd1 << DUTY_BITS) - 64'd1);

   logic [DUTY_BITS-1:0] duty_ff, duty_in;
   logic                 phase_high_ff, phase_high_in;
   logic [PhaseW-1:0]    phase_cnt_ff, phase_cnt_in;
   logic                 dir_ff, dir_in;

   logic [SumW-1:0]   limit, max_w, step_w, sum, d_up, d_down, d_fin;
   logic [LenW-1:0]   len, duty_l, base_l;
   logic [PhaseW-1:0] cnt_next;

   always_comb begin
      max_w  = SumW'(cfg.duty_max);
      step_w = SumW'(cfg.duty_step);
      limit  = (max_w < SumW'(DutyCeil)) ? max_w : SumW'(DutyCeil);
      if (limit > DutyMaskW) begin
         limit = DutyMaskW;
      end

      sum  = SumW'(duty_ff) + step_w;
      d_up = req.key_up ? ((sum > limit) ? limit : sum) : SumW'(duty_ff);
      if (req.key_down) begin
         d_down = (d_up < step_w) ? '0 : d_up - step_w;
      end else begin
         d_down = d_up;
      end
      d_fin   = (d_down > limit) ? limit : d_down;
      duty_in = d_fin[DUTY_BITS-1:0];

      dir_in = dir_ff ^ req.key_reverse;

      duty_l = LenW'(duty_in);
      base_l = LenW'(cfg.period_base);
      if (phase_high_ff) begin
         len = duty_l + LenW'(1);
      end else begin
         len = (base_l > duty_l) ? base_l - duty_l : LenW'(1);
      end

      cnt_next = phase_cnt_ff + PhaseW'(1);
      if (LenW'(cnt_next) >= len) begin
         phase_high_in = ~phase_high_ff;
         phase_cnt_in  = '0;
      end else begin
         phase_high_in = phase_high_ff;
         phase_cnt_in  = cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff       <= DUTY_BITS'(DutyReset);
         phase_high_ff <= 1'b0;
         phase_cnt_ff  <= '0;
         dir_ff        <= 1'b1;
      end else if (en) begin
         duty_ff       <= duty_in;
         phase_high_ff <= phase_high_in;
         phase_cnt_ff  <= phase_cnt_in;
         dir_ff        <= dir_in;
      end
   end

   assign pwm_level = phase_high_ff;
   assign drive_a   = dir_in;
   assign duty_now  = duty_in;

   `ASSERT_CLK(a_duty_in_range, clock, reset, SumW'(duty_ff) <= SumW'(DutyCeil),
      "duty setting above ceiling")
   `ASSERT_CLK(a_hold_when_idle, clock, reset,
      !en |=> $stable(duty_ff) && $stable(phase_cnt_ff) && $stable(dir_ff),
      "drive state moved without a request")
   `ASSERT_CLK(a_phase_restart, clock, reset,
      en && (phase_high_in != phase_high_ff) |=> phase_cnt_ff == '0,
      "phase switched without restarting its count")

endmodule

### hw/rtl/dmpsc_speed.sv
// Encoder edge counter over a gated measurement window.
`include "assert_macros.svh"

module dmpsc_speed
   import dmpsc_pkg::*;
#(
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  cfg_type               cfg,
   input  req_type               req,
   output logic [COUNT_BITS-1:0] speed_pulses,
   output logic                  reverse_seen,
   output logic                  window_toggle
);

   logic [COUNT_BITS-1:0] edge_cnt_ff, edge_cnt_in;
   logic [COUNT_BITS-1:0] latched_ff, latched_in;
   logic                  sign_ff, sign_in;
   logic [GateW-1:0]      gate_cnt_ff, gate_cnt_in;
   logic [IntervalW-1:0]  int_cnt_ff, int_cnt_in;
   logic                  blink_ff, blink_in;

   logic [GateW-1:0]      gate_len, gate_next;
   logic [IntervalW-1:0]  int_len, int_next;
   logic [COUNT_BITS-1:0] edge_acc;

   always_comb begin
      edge_acc = edge_cnt_ff;
      sign_in  = sign_ff;
      if (req.enc_edge) begin
         if (edge_cnt_ff != '1) begin
            edge_acc = edge_cnt_ff + COUNT_BITS'(1);
         end
         sign_in = ~req.enc_b_level;
      end

      gate_len = (cfg.gate_ticks == '0) ? GateW'(1) : cfg.gate_ticks;
      int_len  = (cfg.gate_intervals == '0) ? IntervalW'(1) : cfg.gate_intervals;

      gate_next   = gate_cnt_ff + GateW'(1);
      int_next    = int_cnt_ff + IntervalW'(1);
      gate_cnt_in = gate_next;
      int_cnt_in  = int_cnt_ff;
      edge_cnt_in = edge_acc;
      latched_in  = latched_ff;
      blink_in    = blink_ff;
      if (gate_next >= gate_len) begin
         gate_cnt_in = '0;
         int_cnt_in  = int_next;
         if (int_next >= int_len) begin
            int_cnt_in  = '0;
            latched_in  = edge_acc;
            edge_cnt_in = '0;
            blink_in    = ~blink_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_cnt_ff <= '0;
         latched_ff  <= '0;
         sign_ff     <= 1'b0;
         gate_cnt_ff <= '0;
         int_cnt_ff  <= '0;
         blink_ff    <= 1'b0;
      end else if (en) begin
         edge_cnt_ff <= edge_cnt_in;
         latched_ff  <= latched_in;
         sign_ff     <= sign_in;
         gate_cnt_ff <= gate_cnt_in;
         int_cnt_ff  <= int_cnt_in;
         blink_ff    <= blink_in;
      end
   end

   assign speed_pulses  = latched_in;
   assign reverse_seen  = sign_in;
   assign window_toggle = blink_in;

   `ASSERT_CLK(a_latch_on_gate_end, clock, reset,
      (blink_ff != $past(blink_ff)) |-> gate_cnt_ff == '0 && int_cnt_ff == '0,
      "window latched away from a gate boundary")
   `ASSERT_CLK(a_latch_clears_count, clock, reset,
      (latched_ff != $past(latched_ff)) |-> edge_cnt_ff == '0,
      "edge count not cleared on latch")
   `ASSERT_CLK(a_speed_idle_hold, clock, reset,
      !en |=> $stable(gate_cnt_ff) && $stable(edge_cnt_ff),
      "speed state moved without a request")

endmodule

### hw/rtl/dc_motor_pwm_speed_controller.sv
// Top level of the DC motor PWM speed controller.
//
// One request is one timer tick: key presses (up, down, reverse), an
// encoder A falling-edge flag and the encoder B level, in req_tdata.
// Each request yields exactly one response on rsp_: PWM level, the
// direction pair, the duty setting, the last window's encoder count,
// the rotation sign and a toggle that flips on every latched window.
// Registers are written on csr_; the user must write them only while no
// request is in flight, which the block does not enforce. A taken request
// sits in the input register while the duty/PWM and speed logic works on
// it; its response is registered and held on rsp_ until it is taken.
// Throughput: one request per cycle, set by the two-entry register
// pipeline; req_tready stays high while rsp_tready is high.
// When rsp_tready is low the response holds, the input register fills,
// then req_tready drops until the response is taken.
// Reset (synchronous, active high) loads the register defaults, duty 500,
// forward direction, low PWM phase and cleared counters, and empties the
// pipeline; nothing is pending after reset.
module dc_motor_pwm_speed_controller
   import dmpsc_pkg::*;
#(
   parameter int DUTY_BITS  = DutyBitsDefault,
   parameter int COUNT_BITS = CountBitsDefault,
   localparam int RspFieldW = 5 + DUTY_BITS + COUNT_BITS,
   localparam int RspDataW  = ((RspFieldW + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // key_up, key_down, key_reverse, enc_edge, enc_b_level
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   // pwm_level, drive_a, drive_b, duty_now, speed_pulses, reverse_seen,
   // window_toggle
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_wr_en,
   input  logic [CsrAddrW-1:0] csr_addr,
   input  logic [CsrDataW-1:0] csr_wr_data
);

   cfg_type cfg_ff;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic    advance;

   logic                  pwm_level, drive_a;
   logic [DUTY_BITS-1:0]  duty_now;
   logic [COUNT_BITS-1:0] speed_pulses;
   logic                  reverse_seen, window_toggle;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_step      <= StepReset;
         cfg_ff.duty_max       <= MaxReset;
         cfg_ff.period_base    <= BaseReset;
         cfg_ff.gate_ticks     <= GateReset;
         cfg_ff.gate_intervals <= IntervalReset;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            CSR_DUTY_STEP:      cfg_ff.duty_step      <= csr_wr_data[StepW-1:0];
            CSR_DUTY_MAX:       cfg_ff.duty_max       <= csr_wr_data[MaxW-1:0];
            CSR_PERIOD_BASE:    cfg_ff.period_base    <= csr_wr_data[BaseW-1:0];
            CSR_GATE_TICKS:     cfg_ff.gate_ticks     <= csr_wr_data[GateW-1:0];
            CSR_GATE_INTERVALS: cfg_ff.gate_intervals <= csr_wr_data[IntervalW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_type'(req_tdata[$bits(req_type)-1:0]);
      end
   end

   dmpsc_drive #(
      .DUTY_BITS(DUTY_BITS)
   ) u_drive (
      .clock    (clock),
      .reset    (reset),
      .en       (advance),
      .cfg      (cfg_ff),
      .req      (in_data_ff),
      .pwm_level(pwm_level),
      .drive_a  (drive_a),
      .duty_now (duty_now)
   );

   dmpsc_speed #(
      .COUNT_BITS(COUNT_BITS)
   ) u_speed (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .cfg          (cfg_ff),
      .req          (in_data_ff),
      .speed_pulses (speed_pulses),
      .reverse_seen (reverse_seen),
      .window_toggle(window_toggle)
   );

   assign rsp_data_in = RspDataW'({window_toggle, reverse_seen, speed_pulses, duty_now,
                                   ~drive_a, drive_a, pwm_level});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_CLK(a_ready_when_empty, clock, reset, !rsp_valid_ff |-> req_tready,
      "request stalled with an empty response register")
   `ASSERT_CLK(a_advance_fills, clock, reset, advance |=> rsp_valid_ff,
      "advanced request produced no response")
   `ASSERT_CLK(a_no_drop, clock, reset, in_valid_ff && !advance |=> in_valid_ff,
      "held request dropped")

endmodule
